// ===== hw/rtl/dq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and sizes for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH    = 16;
    localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(p - 1'b1);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dq_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_in_if
// Operation channel: one beat carries an operation and a value.
// ----------------------------------------------------------------------------
interface dq_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic signed [31:0]  value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dq_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_out_if
// Result channel: one beat per operation.
// ----------------------------------------------------------------------------
interface dq_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  popped_value;
    logic signed [31:0]  front_value;
    logic signed [31:0]  back_value;
    logic [4:0]          entry_count;
    logic [1:0]          status;

    modport source (output valid, output popped_value, output front_value,
                    output back_value, output entry_count, output status,
                    input ready);
    modport sink   (input valid, input popped_value, input front_value,
                    input back_value, input entry_count, input status,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer deque of signed 32-bit values with cached end entries.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  i_in     in   valid/ready   operation, value
//  o_out    out  valid/ready   popped_value, front_value, back_value,
//                              entry_count, status
//
//  Pushes, dropped pushes, pops on empty and pops that empty the queue put
//  their result straight into the result register. A pop that leaves entries
//  first fetches the new end entry through the store's synchronous read port.
//  Reset clears pointers, count and handshake state; the store is not cleared.
//  No beat is taken while a result is held and not taken, or a read is open.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dq_in_if.sink     i_in,
    dq_out_if.source  o_out
);
    import dq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0] r_front, n_front;
    logic [DATA_W-1:0] r_back, n_back;
    logic [DATA_W-1:0] r_pop_val, n_pop_val;
    logic              r_pop_front, n_pop_front;
    logic [DATA_W-1:0] r_rd_data;

    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_popped, n_out_popped;
    logic [DATA_W-1:0] r_out_front, n_out_front;
    logic [DATA_W-1:0] r_out_back, n_out_back;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    t_status           r_out_status, n_out_status;

    logic              mem_we;
    logic [PTR_W-1:0]  mem_wa;
    logic [DATA_W-1:0] mem_wd;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;

    logic              in_ready;
    logic              in_fire;
    logic              is_full;
    logic              is_empty;
    logic [PTR_W-1:0]  tail_prev;

    assign is_full   = (r_count == CNT_W'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign tail_prev = ring_prev(r_tail);
    assign in_ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_fire   = i_in.valid && in_ready;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_front      = r_front;
        n_back       = r_back;
        n_pop_val    = r_pop_val;
        n_pop_front  = r_pop_front;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_popped = r_out_popped;
        n_out_front  = r_out_front;
        n_out_back   = r_out_back;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_wa       = r_tail;
        mem_wd       = i_in.value;
        rd_en        = 1'b0;
        rd_addr      = ring_next(r_head);

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    // default result: state unchanged
                    n_out_valid  = 1'b1;
                    n_out_popped = '0;
                    n_out_front  = is_empty ? '0 : r_front;
                    n_out_back   = is_empty ? '0 : r_back;
                    n_out_count  = COUNT_W'(r_count);
                    n_out_status = ST_OK;
                    unique case (t_op'(i_in.operation))
                        OP_PUSH_BACK: begin
                            if (is_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                mem_we      = 1'b1;
                                mem_wa      = r_tail;
                                n_tail      = ring_next(r_tail);
                                n_count     = CNT_W'(r_count + 1'b1);
                                n_back      = i_in.value;
                                n_front     = is_empty ? i_in.value : r_front;
                                n_out_front = n_front;
                                n_out_back  = n_back;
                                n_out_count = COUNT_W'(n_count);
                            end
                        end
                        OP_PUSH_FRONT: begin
                            if (is_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                mem_we      = 1'b1;
                                mem_wa      = ring_prev(r_head);
                                n_head      = ring_prev(r_head);
                                n_count     = CNT_W'(r_count + 1'b1);
                                n_front     = i_in.value;
                                n_back      = is_empty ? i_in.value : r_back;
                                n_out_front = n_front;
                                n_out_back  = n_back;
                                n_out_count = COUNT_W'(n_count);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (is_empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_count     = CNT_W'(r_count - 1'b1);
                                n_pop_front = (t_op'(i_in.operation) == OP_POP_FRONT);
                                n_pop_val   = n_pop_front ? r_front : r_back;
                                if (n_pop_front) begin
                                    n_head  = ring_next(r_head);
                                    rd_addr = ring_next(r_head);
                                end else begin
                                    n_tail  = tail_prev;
                                    rd_addr = ring_prev(tail_prev);
                                end
                                n_out_popped = n_pop_val;
                                n_out_front  = '0;
                                n_out_back   = '0;
                                n_out_count  = COUNT_W'(n_count);
                                if (n_count != '0) begin
                                    // new end entry comes from the store
                                    rd_en       = 1'b1;
                                    n_out_valid = 1'b0;
                                    n_state     = S_READ;
                                end
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                if (r_pop_front) begin
                    n_front = r_rd_data;
                end else begin
                    n_back = r_rd_data;
                end
                n_out_valid  = 1'b1;
                n_out_popped = r_pop_val;
                n_out_front  = n_front;
                n_out_back   = n_back;
                n_out_count  = COUNT_W'(r_count);
                n_out_status = ST_OK;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front      <= n_front;
        r_back       <= n_back;
        r_pop_val    <= n_pop_val;
        r_pop_front  <= n_pop_front;
        r_out_popped <= n_out_popped;
        r_out_front  <= n_out_front;
        r_out_back   <= n_out_back;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.popped_value = r_out_popped;
    assign o_out.front_value  = r_out_front;
    assign o_out.back_value   = r_out_back;
    assign o_out.entry_count  = r_out_count;
    assign o_out.status       = r_out_status;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_read_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result held during store read");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_in.operation[1] && !is_full)
        |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("push did not grow count");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_out_valid && r_state == S_IDLE))
        else $error("store read did not finish in one cycle");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_EMPTY)
        |-> (r_out_popped == '0 && r_out_count == '0))
        else $error("bad pop-on-empty result");
`endif

endmodule
`default_nettype wire

// ===== test/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Drives push/pop beats into the deque with random gaps on both channels.
// A scoreboard tracks the ring contents and checks every result beat.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
    import dq_pkg::*;

    localparam int NUM_RANDOM  = 1500;
    localparam int PHASE_LEN   = 100;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_TAIL  = 8;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped;
        logic signed [DATA_W-1:0] front;
        logic signed [DATA_W-1:0] back;
        logic [COUNT_W-1:0]       count;
        t_status                  status;
    } t_dq_result;

    class deque_scoreboard;
        logic signed [DATA_W-1:0] entries [DEPTH];
        logic [PTR_W-1:0]         head_idx;
        logic [PTR_W-1:0]         tail_idx;
        logic [CNT_W-1:0]         fill;
        t_dq_result               pending_results [$];
        int                       mismatches;

        function new();
            foreach (entries[i]) entries[i] = '0;
            head_idx   = '0;
            tail_idx   = '0;
            fill       = '0;
            mismatches = 0;
        endfunction

        function logic [PTR_W-1:0] wrap_up(input logic [PTR_W-1:0] p);
            return (int'(p) == DEPTH - 1) ? '0 : PTR_W'(p + 1'b1);
        endfunction

        function logic [PTR_W-1:0] wrap_down(input logic [PTR_W-1:0] p);
            return (p == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(p - 1'b1);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Apply one accepted operation to the tracked deque and queue its result.
        function void note_op(input t_op op, input logic signed [DATA_W-1:0] val);
            t_dq_result r;
            r        = '0;
            r.status = ST_OK;
            if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
                if (int'(fill) >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (op == OP_PUSH_BACK) begin
                    entries[tail_idx] = val;
                    tail_idx = wrap_up(tail_idx);
                    fill++;
                end else begin
                    head_idx = wrap_down(head_idx);
                    entries[head_idx] = val;
                    fill++;
                end
            end else begin
                if (fill == '0) begin
                    r.status = ST_EMPTY;
                end else if (op == OP_POP_FRONT) begin
                    r.popped = entries[head_idx];
                    head_idx = wrap_up(head_idx);
                    fill--;
                end else begin
                    tail_idx = wrap_down(tail_idx);
                    r.popped = entries[tail_idx];
                    fill--;
                end
            end
            if (fill != '0) begin
                r.front = entries[head_idx];
                r.back  = entries[wrap_down(tail_idx)];
            end
            r.count = COUNT_W'(fill);
            pending_results.push_back(r);
        endfunction

        function void check_result(input t_dq_result got);
            t_dq_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing pending: popped %0d count %0d",
                             $time, got.popped, got.count);
                return;
            end
            want = pending_results.pop_front();
            if (got.popped !== want.popped || got.front !== want.front ||
                got.back !== want.back || got.count !== want.count ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("%0t: mismatch exp/act popped %0d/%0d front %0d/%0d ",
                           $time, want.popped, got.popped, want.front, got.front);
                    $display("back %0d/%0d count %0d/%0d status %0d/%0d",
                             want.back, got.back, want.count, got.count,
                             want.status, got.status);
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic idle_on = 1'b0;
    int   stall_cycles = 0;

    deque_scoreboard sb = new();

    dq_in_if  in_ch ();
    dq_out_if out_ch ();

    double_ended_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_PUSH_BACK;
        in_ch.value     <= '0;
        out_ch.ready    <= 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // One operation beat; valid stays high across back-to-back beats.
    task automatic send_op(input t_op op, input logic signed [DATA_W-1:0] val);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.value     <= val;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        sb.note_op(op, val);
    endtask

    // Result side: random stall before each beat, then check it.
    initial begin
        t_dq_result got;
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            got.popped = out_ch.popped_value;
            got.front  = out_ch.front_value;
            got.back   = out_ch.back_value;
            got.count  = out_ch.entry_count;
            got.status = t_status'(out_ch.status);
            sb.check_result(got);
        end
    end

    // Watchdog: cycles without any beat on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("double_ended_queue test failed");
            $finish;
        end
    end

    initial begin
        int push_pct;
        t_op op;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pops on empty, extreme values, fill up, pushes when full
        send_op(OP_POP_FRONT, 32'sh7fffffff);
        send_op(OP_POP_BACK, 32'sh80000000);
        send_op(OP_PUSH_BACK, 32'sh7fffffff);
        send_op(OP_PUSH_FRONT, 32'sh80000000);
        send_op(OP_POP_FRONT, -32'sd1);
        send_op(OP_POP_BACK, '0);
        for (int i = 0; i < DEPTH; i++) begin
            send_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
        end
        send_op(OP_PUSH_BACK, -32'sd1);
        send_op(OP_PUSH_FRONT, '0);

        // random phases with push-heavy, balanced and pop-heavy mixes
        push_pct = 50;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % PHASE_LEN == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < push_pct) begin
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            end else begin
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            end
            send_op(op, pick_value());
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("double_ended_queue test passed");
        end else begin
            $display("double_ended_queue test failed");
        end
        $finish;
    end

endmodule
